// ===== sv/pacrt_pkg.sv =====
// Shared types, constants and helpers for the per-agent clock refcount table.
package pacrt_pkg;

  // Table geometry.
  localparam int unsigned NUM_AGENTS = 2;
  localparam int unsigned NUM_CLOCKS = 128;
  localparam int unsigned TBL_DEPTH  = NUM_AGENTS * NUM_CLOCKS;

  localparam int unsigned AGT_W  = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
  localparam int unsigned CLK_W  = (NUM_CLOCKS > 1) ? $clog2(NUM_CLOCKS) : 1;
  localparam int unsigned ADDR_W = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  localparam logic [AGT_W-1:0] AGT_LAST = AGT_W'(NUM_AGENTS - 1);
  localparam logic [CLK_W-1:0] CLK_LAST = CLK_W'(NUM_CLOCKS - 1);

  // Counter limits.
  localparam logic [7:0] CNT_MAX   = 8'd255;
  localparam logic [8:0] CLEAR_SAT = 9'd256;

  // Configuration register map.
  localparam int unsigned APB_AW       = 3;
  localparam logic        REG_PLATFORM = 1'b0;

  // Request kinds.
  typedef enum logic [2:0] {
    K_ENABLE      = 3'd0,
    K_DISABLE     = 3'd1,
    K_QUERY       = 3'd2,
    K_RESET_AGENT = 3'd3,
    K_RESET_ALL   = 3'd4
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_REFUSED = 2'd2
  } status_e;

  // How a request is serviced.
  typedef enum logic [1:0] {
    CL_RMW,
    CL_WALK,
    CL_BAD
  } req_class_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic rmw_exec;
    logic walk_step;
    logic load_fin;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    req_class_e in_class;
    logic       walk_last;
    logic       out_free;
  } dp_stat_t;

  // Linear table address of one agent and clock.
  function automatic logic [ADDR_W-1:0] rc_addr(input logic [AGT_W-1:0] agent,
                                                input logic [CLK_W-1:0] clock);
    logic [ADDR_W-1:0] row;
    row = ADDR_W'(ADDR_W'(agent) * ADDR_W'(NUM_CLOCKS));
    return ADDR_W'(row + ADDR_W'(clock));
  endfunction

endpackage

// ===== sv/pacrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pacrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old word when the same entry is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pacrt_ctrl.sv =====
// Controller state machine sequencing table clears, updates and row walks.
module pacrt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pacrt_pkg::dp_stat_t  stat_i,
  output pacrt_pkg::ctrl_cmd_t cmd_o
);
  import pacrt_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RMW,
    S_WALK,
    S_FIN
  } state_e;

  state_e    state_q, state_d;
  ctrl_cmd_t cmd;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_INIT: begin
        cmd.walk_step = 1'b1;
        if (stat_i.walk_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          case (stat_i.in_class)
            CL_RMW:  state_d = S_RMW;
            CL_WALK: state_d = S_WALK;
            default: state_d = S_FIN;
          endcase
        end
      end
      S_RMW: begin
        if (stat_i.out_free) begin
          cmd.rmw_exec = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat_i.walk_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd.load_fin = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register; the table is cleared first after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

endmodule

// ===== sv/pacrt_dp.sv =====
// Datapath: request decode, count table, row walker and result word register.
module pacrt_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pacrt_pkg::ctrl_cmd_t cmd_i,
  output pacrt_pkg::dp_stat_t  stat_o,
  input  logic [2:0]           in_kind_i,
  input  logic [7:0]           in_agent_i,
  input  logic [9:0]           in_clock_i,
  input  logic                 in_gate_i,
  input  logic [3:0]           platform_agent_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [1:0]           out_status_o,
  output logic                 out_enabled_o,
  output logic [7:0]           out_ref_count_o,
  output logic [8:0]           out_cleared_o
);
  import pacrt_pkg::*;

  typedef enum logic [1:0] {
    WALK_INIT,
    WALK_ROW,
    WALK_ALL
  } walk_mode_e;

  // Request decode.
  logic       agent_ok, clock_ok;
  req_class_e in_class;
  logic [ADDR_W-1:0] in_addr;

  assign agent_ok = (in_agent_i < 8'(NUM_AGENTS));
  assign clock_ok = ({1'b0, in_clock_i} < 11'(NUM_CLOCKS));
  assign in_addr  = rc_addr(in_agent_i[AGT_W-1:0], in_clock_i[CLK_W-1:0]);

  always_comb begin
    case (in_kind_i)
      K_ENABLE, K_DISABLE, K_QUERY: in_class = (agent_ok && clock_ok) ? CL_RMW : CL_BAD;
      K_RESET_AGENT:                in_class = agent_ok ? CL_WALK : CL_BAD;
      K_RESET_ALL:                  in_class = CL_WALK;
      default:                      in_class = CL_BAD;
    endcase
  end

  // Captured request.
  logic [2:0]        kind_q;
  logic              gate_q;
  logic [ADDR_W-1:0] addr_q;
  req_class_e        class_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= in_kind_i;
      gate_q  <= in_gate_i;
      addr_q  <= in_addr;
      class_q <= in_class;
    end
  end

  // Row walker state.
  walk_mode_e        mode_q, mode_d;
  logic [AGT_W-1:0]  agent_ctr_q, agent_ctr_d;
  logic [CLK_W-1:0]  clk_ctr_q, clk_ctr_d;
  logic              pend_q, pend_d;
  logic [8:0]        acc_q, acc_d, acc_next;
  logic [ADDR_W-1:0] walk_addr;
  logic              skip, count_en, walk_last;
  logic [7:0]        rd;

  assign walk_addr = rc_addr(agent_ctr_q, clk_ctr_q);
  assign skip      = (mode_q == WALK_ALL) && (4'(agent_ctr_q) == platform_agent_i);
  assign count_en  = (mode_q != WALK_INIT) && !skip;
  assign walk_last = (clk_ctr_q == CLK_LAST) &&
                     ((mode_q == WALK_ROW) || (agent_ctr_q == AGT_LAST));

  // Saturating count of nonzero entries seen by the walk.
  assign acc_next = (acc_q == CLEAR_SAT) ? acc_q
                                         : 9'(acc_q + 9'(pend_q && (rd != 8'd0)));

  always_comb begin
    mode_d      = mode_q;
    agent_ctr_d = agent_ctr_q;
    clk_ctr_d   = clk_ctr_q;
    pend_d      = cmd_i.walk_step && count_en;
    acc_d       = acc_next;
    if (cmd_i.capture) begin
      acc_d     = '0;
      clk_ctr_d = '0;
      if (in_kind_i == K_RESET_ALL) begin
        mode_d      = WALK_ALL;
        agent_ctr_d = '0;
      end else begin
        mode_d      = WALK_ROW;
        agent_ctr_d = in_agent_i[AGT_W-1:0];
      end
    end else if (cmd_i.walk_step) begin
      if (clk_ctr_q == CLK_LAST) begin
        clk_ctr_d   = '0;
        agent_ctr_d = AGT_W'(agent_ctr_q + 1'b1);
      end else begin
        clk_ctr_d = CLK_W'(clk_ctr_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= WALK_INIT;
      agent_ctr_q <= '0;
      clk_ctr_q   <= '0;
      pend_q      <= 1'b0;
      acc_q       <= '0;
    end else begin
      mode_q      <= mode_d;
      agent_ctr_q <= agent_ctr_d;
      clk_ctr_q   <= clk_ctr_d;
      pend_q      <= pend_d;
      acc_q       <= acc_d;
    end
  end

  // Read-modify-write of one count.
  logic [7:0] v_new;
  status_e    rmw_status;

  always_comb begin
    v_new      = rd;
    rmw_status = ST_OK;
    case (kind_q)
      K_ENABLE: begin
        if (rd == CNT_MAX) begin
          rmw_status = ST_INVALID;
        end else if (!gate_q) begin
          rmw_status = ST_REFUSED;
        end else begin
          v_new = 8'(rd + 8'd1);
        end
      end
      K_DISABLE: begin
        if (rd == 8'd0) begin
          rmw_status = ST_INVALID;
        end else if (!gate_q) begin
          rmw_status = ST_REFUSED;
        end else begin
          v_new = 8'(rd - 8'd1);
        end
      end
      default: ;
    endcase
  end

  // Count table.
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata;

  assign ram_re    = (cmd_i.capture && (in_class == CL_RMW)) ||
                     (cmd_i.walk_step && count_en);
  assign ram_raddr = cmd_i.capture ? in_addr : walk_addr;
  assign ram_we    = cmd_i.rmw_exec || (cmd_i.walk_step && !skip);
  assign ram_waddr = cmd_i.rmw_exec ? addr_q : walk_addr;
  assign ram_wdata = cmd_i.rmw_exec ? v_new : 8'd0;

  pacrt_ram #(
    .WIDTH (8),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  // Result word register.
  logic       out_valid_q;
  logic [1:0] out_status_q;
  logic       out_enabled_q;
  logic [7:0] out_ref_count_q;
  logic [8:0] out_cleared_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rmw_exec || cmd_i.load_fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rmw_exec) begin
      out_status_q    <= rmw_status;
      out_enabled_q   <= (v_new != 8'd0);
      out_ref_count_q <= v_new;
      out_cleared_q   <= '0;
    end else if (cmd_i.load_fin) begin
      out_status_q    <= (class_q == CL_BAD) ? ST_INVALID : ST_OK;
      out_enabled_q   <= 1'b0;
      out_ref_count_q <= '0;
      out_cleared_q   <= (class_q == CL_BAD) ? 9'd0 : acc_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_enabled_o   = out_enabled_q;
  assign out_ref_count_o = out_ref_count_q;
  assign out_cleared_o   = out_cleared_q;

  assign stat_o.in_class  = in_class;
  assign stat_o.walk_last = walk_last;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rmw_exec || cmd_i.load_fin) |-> (!out_valid_q || out_ready_i))
    else $error("result word loaded over an untaken word");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.walk_step && (cmd_i.rmw_exec || cmd_i.capture)))
    else $error("walk step overlaps a table update or capture");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_cleared_q <= CLEAR_SAT))
    else $error("cleared count above saturation");

  a_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_enabled_q == (out_ref_count_q != 8'd0)))
    else $error("enabled flag disagrees with count");
`endif

endmodule

// ===== sv/per_agent_clock_refcount_table.sv =====
// Top level of the per-agent clock enable reference count table.
// Enable, disable, query and rejected words: the result word is loaded in the RMW or FIN state once
// the result register is free. Agent reset walks the agent's row, reset-all the whole table, before
// FIN; the row walker visits one entry per cycle. No word is accepted until the previous one is done.
// A new word is accepted while the previous result word still waits to be taken.
// After reset the table is cleared before s_tready_o rises.
module per_agent_clock_refcount_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request stream.
  input  logic                         s_tvalid_i,
  output logic                         s_tready_o,
  input  logic [23:0]                  s_tdata_i,  // agent_idx[7:0], clock_id[17:8], gate_ok[18]
  input  logic [2:0]                   s_tuser_i,  // kind[2:0]
  // Result stream.
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [23:0]                  m_tdata_o,  // status[1:0], enabled[2], ref_count[10:3],
                                                   // cleared_count[19:11]
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pacrt_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import pacrt_pkg::*;

  // Platform agent register.
  logic [3:0] platform_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PLATFORM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      platform_q <= '0;
    end else if (cfg_wr) begin
      platform_q <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == REG_PLATFORM) ? {28'd0, platform_q} : 32'd0;

  // Controller and datapath.
  ctrl_cmd_t  cmd;
  dp_stat_t   stat;
  logic [1:0] out_status;
  logic       out_enabled;
  logic [7:0] out_ref_count;
  logic [8:0] out_cleared;

  pacrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pacrt_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .in_kind_i        (s_tuser_i),
    .in_agent_i       (s_tdata_i[7:0]),
    .in_clock_i       (s_tdata_i[17:8]),
    .in_gate_i        (s_tdata_i[18]),
    .platform_agent_i (platform_q),
    .out_ready_i      (m_tready_i),
    .out_valid_o      (m_tvalid_o),
    .out_status_o     (out_status),
    .out_enabled_o    (out_enabled),
    .out_ref_count_o  (out_ref_count),
    .out_cleared_o    (out_cleared)
  );

  assign m_tdata_o = {4'd0, out_cleared, out_ref_count, out_enabled, out_status};

endmodule
